// File: src/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants, types and tables for quaternion to Euler conversion.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int NSTEPS       = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    // vector datapath width: products up to 2^30, sums with growth
    localparam int VW = 36;
    // angle width, Q.24 radians plus margin
    localparam int AW = 28;
    // square root: 58-bit radicand, 29-bit root, one result bit per cell
    localparam int RADW  = 58;
    localparam int ROOTW = 29;

    localparam logic signed [AW-1:0] PI_Q24 = AW'(52707179);
    localparam logic signed [15:0]   PI_Q13 = 16'sd25736;
    localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [VW-1:0] ONE_Q28 = VW'(64'sd268435456);

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [AW-1:0] z;
        logic                 done;
    } vec_t;

    typedef struct packed {
        logic [RADW-1:0]  rem;
        logic [ROOTW-1:0] root;
    } sqrt_t;

    function automatic logic signed [AW-1:0] atan_tab(input logic [4:0] i);
        logic signed [AW-1:0] r;
        begin
            case (i)
                5'd0:  r = AW'(13176795);
                5'd1:  r = AW'(7778716);
                5'd2:  r = AW'(4110060);
                5'd3:  r = AW'(2086331);
                5'd4:  r = AW'(1047214);
                5'd5:  r = AW'(524117);
                5'd6:  r = AW'(262123);
                5'd7:  r = AW'(131069);
                5'd8:  r = AW'(65536);
                5'd9:  r = AW'(32768);
                5'd10: r = AW'(16384);
                5'd11: r = AW'(8192);
                5'd12: r = AW'(4096);
                5'd13: r = AW'(2048);
                5'd14: r = AW'(1024);
                5'd15: r = AW'(512);
                5'd16: r = AW'(256);
                5'd17: r = AW'(128);
                5'd18: r = AW'(64);
                5'd19: r = AW'(32);
                5'd20: r = AW'(16);
                5'd21: r = AW'(8);
                5'd22: r = AW'(4);
                5'd23: r = AW'(2);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Q.24 angle rounded half up to Q3.13, saturated to +-lim
    function automatic logic signed [15:0] to_q13(input logic signed [AW-1:0] a,
                                                  input logic signed [15:0] lim);
        logic signed [AW:0] s;
        logic signed [AW:0] r;
        begin
            s = {a[AW-1], a} + (AW+1)'(1024);
            r = s >>> 11;
            if (r > (AW+1)'(lim))
                r = (AW+1)'(lim);
            if (r < -(AW+1)'(lim))
                r = -(AW+1)'(lim);
            return r[15:0];
        end
    endfunction

endpackage

// File: src/quaternion_to_euler_angles.sv
// Pipeline: 49 register stages (3 + 29 + 16 + 1).
// Throughput: one request per cycle; the whole pipe advances when the output
// register is empty or being drained.
// Stages: products, sums, prerotation/radicand, 29 root cells, 16 CORDIC cells, round.
// Reset (aresetn low, synchronous) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Quaternion to roll/pitch/yaw via pipelined CORDIC chains.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // roll_angle, pitch_angle, yaw_angle, zero pad
    output logic        m_tuser    // pitch_clamped
);

    localparam int VW = qte_pkg::VW;
    localparam int AW = qte_pkg::AW;
    localparam int NS = qte_pkg::NSTEPS;
    localparam int NR = qte_pkg::ROOTW;
    localparam int DEPTH = 3 + NR + NS;

    logic en;
    logic [DEPTH-1:0] vld_reg;
    logic out_vld_reg;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // stage 1: products
    logic signed [31:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wz_reg;
    logic signed [31:0] p_xy_reg, p_zz_reg, p_wy_reg, p_zx_reg;
    logic signed [15:0] qw, qx, qy, qz;
    assign qw = s_tdata[15:0];
    assign qx = s_tdata[31:16];
    assign qy = s_tdata[47:32];
    assign qz = s_tdata[63:48];

    always_ff @(posedge aclk) begin
        if (en) begin
            p_wx_reg <= qw * qx;
            p_yz_reg <= qy * qz;
            p_xx_reg <= qx * qx;
            p_yy_reg <= qy * qy;
            p_wz_reg <= qw * qz;
            p_xy_reg <= qx * qy;
            p_zz_reg <= qz * qz;
            p_wy_reg <= qw * qy;
            p_zx_reg <= qz * qx;
        end
    end

    // stage 2: sums
    logic signed [VW-1:0] sinr_reg, cosr_reg, siny_reg, cosy_reg, sinp_reg;
    logic signed [VW-1:0] sinp_c;
    assign sinp_c = (VW'(p_wy_reg) - VW'(p_zx_reg)) <<< 1;

    always_ff @(posedge aclk) begin
        if (en) begin
            sinr_reg <= (VW'(p_wx_reg) + VW'(p_yz_reg)) <<< 1;
            cosr_reg <= qte_pkg::ONE_Q28 - ((VW'(p_xx_reg) + VW'(p_yy_reg)) <<< 1);
            siny_reg <= (VW'(p_wz_reg) + VW'(p_xy_reg)) <<< 1;
            cosy_reg <= qte_pkg::ONE_Q28 - ((VW'(p_yy_reg) + VW'(p_zz_reg)) <<< 1);
            sinp_reg <= sinp_c;
        end
    end

    // stage 3: pitch square, clamp flag, roll/yaw prerotation
    logic [qte_pkg::RADW-1:0] rad_reg;
    logic signed [VW-1:0] sinp3_reg;
    logic [55:0] s2;
    logic [27:0] mag;
    logic clamp_c;
    qte_pkg::vec_t r_pre, y_pre;

    assign clamp_c = (sinp_reg >= qte_pkg::ONE_Q28) || (sinp_reg <= -qte_pkg::ONE_Q28);
    assign mag     = sinp_reg[VW-1] ? 28'(-sinp_reg) : 28'(sinp_reg);
    assign s2      = mag * mag;

    function automatic qte_pkg::vec_t prerot(input logic signed [VW-1:0] yy,
                                             input logic signed [VW-1:0] xx);
        qte_pkg::vec_t v;
        begin
            v.x = xx;
            v.y = yy;
            v.z = '0;
            v.done = (xx == '0) && (yy == '0);
            if (xx[VW-1]) begin
                v.z = yy[VW-1] ? -qte_pkg::PI_Q24 : qte_pkg::PI_Q24;
                v.x = -xx;
                v.y = -yy;
            end
            return v;
        end
    endfunction

    assign r_pre = prerot(sinr_reg, cosr_reg);
    assign y_pre = prerot(siny_reg, cosy_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg    <= clamp_c ? '0 : (qte_pkg::RADW'(58'd1 << 56) - qte_pkg::RADW'(s2));
            sinp3_reg  <= sinp_reg;
        end
    end

    // roll/yaw delay line through the root stages, pitch root cells
    qte_pkg::vec_t rd [0:NR];
    qte_pkg::vec_t yd [0:NR];
    qte_pkg::sqrt_t sq [0:NR];
    logic signed [VW-1:0] sd [0:NR];
    logic [1:0] cl [0:NR];    // pitch sign, clamp flag

    always_ff @(posedge aclk) begin
        if (en) begin
            rd[0] <= r_pre;
            yd[0] <= y_pre;
            cl[0] <= {sinp_reg[VW-1], clamp_c};
        end
    end
    assign sq[0].rem  = rad_reg;
    assign sq[0].root = '0;
    assign sd[0]      = sinp3_reg;

    // rd/yd/cl index 0 aligns with stage 3 output (same as rad_reg)
    genvar g;
    generate
        for (g = 0; g < NR; g++) begin : g_root
            qte_sqrt_cell u_sqrt (
                .aclk    (aclk),
                .en      (en),
                .step    (5'(g)),
                .sin     (sq[g]),
                .side_in (sd[g]),
                .sout    (sq[g+1]),
                .side_out(sd[g+1])
            );
            always_ff @(posedge aclk) begin
                if (en) begin
                    rd[g+1] <= rd[g];
                    yd[g+1] <= yd[g];
                    cl[g+1] <= cl[g];
                end
            end
        end
    endgenerate

    // pitch CORDIC input
    qte_pkg::vec_t p_pre;
    always_comb begin
        p_pre.x    = VW'({1'b0, sq[NR].root});
        p_pre.y    = sd[NR];
        p_pre.z    = '0;
        p_pre.done = (sq[NR].root == '0) && (sd[NR] == '0);
    end

    qte_pkg::vec_t rc [0:NS];
    qte_pkg::vec_t yc [0:NS];
    qte_pkg::vec_t pc [0:NS];
    logic [1:0] cc [0:NS];
    assign rc[0] = rd[NR];
    assign yc[0] = yd[NR];
    assign pc[0] = p_pre;
    assign cc[0] = cl[NR];

    generate
        for (g = 0; g < NS; g++) begin : g_cordic
            qte_cordic_cell u_roll (
                .aclk(aclk), .en(en), .step(5'(g)), .vin(rc[g]), .vout(rc[g+1])
            );
            qte_cordic_cell u_yaw (
                .aclk(aclk), .en(en), .step(5'(g)), .vin(yc[g]), .vout(yc[g+1])
            );
            qte_cordic_cell u_pitch (
                .aclk(aclk), .en(en), .step(5'(g)), .vin(pc[g]), .vout(pc[g+1])
            );
            always_ff @(posedge aclk) begin
                if (en) begin
                    cc[g+1] <= cc[g];
                end
            end
        end
    endgenerate

    // final stage: rounding and output register
    logic signed [15:0] roll_reg, yaw_reg;
    logic signed [14:0] pitch_reg;
    logic clamped_reg;
    logic signed [15:0] pitch_r;
    logic signed [15:0] sgn_half;

    assign pitch_r  = qte_pkg::to_q13(pc[NS].z, qte_pkg::HALF_PI_Q13);
    assign sgn_half = cc[NS][1] ? -qte_pkg::HALF_PI_Q13 : qte_pkg::HALF_PI_Q13;

    always_ff @(posedge aclk) begin
        if (en) begin
            roll_reg    <= qte_pkg::to_q13(rc[NS].z, qte_pkg::PI_Q13);
            yaw_reg     <= qte_pkg::to_q13(yc[NS].z, qte_pkg::PI_Q13);
            pitch_reg   <= cc[NS][0] ? sgn_half[14:0] : pitch_r[14:0];
            clamped_reg <= cc[NS][0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[DEPTH-2:0], s_tvalid};
            out_vld_reg <= vld_reg[DEPTH-1];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, yaw_reg, pitch_reg, roll_reg};
    assign m_tuser  = clamped_reg;

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready mismatch");
    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(pitch_reg) <= 15'sd12868 && $signed(pitch_reg) >= -15'sd12868))
        else $error("pitch out of range");
`endif

endmodule

// File: src/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring CORDIC micro-rotation with a fixed shift, registered.
// ----------------------------------------------------------------------------
module qte_cordic_cell (
    input  logic          aclk,
    input  logic          en,
    input  logic [4:0]    step,
    input  qte_pkg::vec_t vin,
    output qte_pkg::vec_t vout
);

    qte_pkg::vec_t v_next;
    qte_pkg::vec_t v_reg;

    always_comb begin
        v_next = vin;
        if (vin.y == '0) begin
            v_next.done = 1'b1;
        end else if (!vin.done) begin
            if (!vin.y[qte_pkg::VW-1]) begin
                v_next.x = vin.x + (vin.y >>> step);
                v_next.y = vin.y - (vin.x >>> step);
                v_next.z = vin.z + qte_pkg::atan_tab(step);
            end else begin
                v_next.x = vin.x - (vin.y >>> step);
                v_next.y = vin.y + (vin.x >>> step);
                v_next.z = vin.z - qte_pkg::atan_tab(step);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg <= v_next;
        end
    end

    assign vout = v_reg;

endmodule

// File: src/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One restoring square-root digit, registered, with a carried side word.
// ----------------------------------------------------------------------------
module qte_sqrt_cell (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [4:0]                step,
    input  qte_pkg::sqrt_t            sin,
    input  logic signed [qte_pkg::VW-1:0] side_in,
    output qte_pkg::sqrt_t            sout,
    output logic signed [qte_pkg::VW-1:0] side_out
);

    qte_pkg::sqrt_t s_next;
    qte_pkg::sqrt_t s_reg;
    logic signed [qte_pkg::VW-1:0] side_reg;
    logic [qte_pkg::RADW+1:0] trial;
    logic [5:0] sh;

    assign sh = 6'(2 * (qte_pkg::ROOTW - 1)) - {step, 1'b0};

    always_comb begin
        s_next = sin;
        // trial = (4*root + 1) << sh, compared to remainder
        trial = (({2'b00, qte_pkg::RADW'(sin.root)} << 2) | (qte_pkg::RADW+2)'(1)) << sh;
        s_next.root = sin.root << 1;
        if ({2'b00, sin.rem} >= trial) begin
            s_next.rem  = sin.rem - trial[qte_pkg::RADW-1:0];
            s_next.root = (sin.root << 1) | qte_pkg::ROOTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg    <= s_next;
            side_reg <= side_in;
        end
    end

    assign sout     = s_reg;
    assign side_out = side_reg;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks quaternion_to_euler_angles against a bit-exact predictor of the
// fixed-point CORDIC roll/pitch/yaw conversion, with random stalls on both
// sides of the stream.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } angles_t;

    localparam longint ONE_Q28_L = 64'sd268435456;
    localparam longint PI_Q24_L  = 64'sd52707179;
    localparam int     LIMIT     = 400000;

    localparam longint ATAN_Q24 [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;    // quat_w, quat_x, quat_y, quat_z
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // roll_angle, pitch_angle, yaw_angle, zero pad
    logic        m_tuser;         // pitch_clamped

    angles_t angles_due[$];
    int      n_requests = 0;
    int      n_results = 0;
    int      n_clamped = 0;
    int      n_errors = 0;
    int      cycles = 0;

    quaternion_to_euler_angles u_top (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint vector_angle(longint y, longint x);
        longint z, nx, ny;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_Q24_L : -PI_Q24_L;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < qte_pkg::NSTEPS; i++) begin
            if (y == 0)
                break;
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ATAN_Q24[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ATAN_Q24[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic longint round_q13(longint a, longint lim);
        longint r;
        r = (a + 1024) >>> 11;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic angles_t euler_of(logic [63:0] q);
        longint w, x, y, z, sinr, cosr, siny, cosy, sinp, c;
        longint unsigned rad;
        angles_t a;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        sinr = 2 * (w * x + y * z);
        cosr = ONE_Q28_L - 2 * (x * x + y * y);
        siny = 2 * (w * z + x * y);
        cosy = ONE_Q28_L - 2 * (y * y + z * z);
        sinp = 2 * (w * y - z * x);
        a.roll = 16'(round_q13(vector_angle(sinr, cosr), 25736));
        a.yaw  = 16'(round_q13(vector_angle(siny, cosy), 25736));
        if (sinp >= ONE_Q28_L || sinp <= -ONE_Q28_L) begin
            a.pitch   = (sinp > 0) ? 15'sd12868 : -15'sd12868;
            a.clamped = 1'b1;
        end else begin
            rad = (64'd1 << 56) - longint'(sinp * sinp);
            c = longint'(floor_sqrt(rad));
            a.pitch   = 15'(round_q13(vector_angle(sinp, c), 12868));
            a.clamped = 1'b0;
        end
        return a;
    endfunction

    task automatic idle_gap(output int n);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            n = 0;
        else if (r < 92)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 40);
    endtask

    task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z);
        logic hs;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x, w};
        do begin
            @(negedge aclk);
            hs = s_tready;
            @(posedge aclk);
        end while (!hs);
        angles_due = {angles_due, euler_of({z, y, x, w})};
        n_requests++;
        idle_gap(gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // result checker: handshake seen at negedge completes on the next posedge
    always @(negedge aclk) begin
        angles_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (angles_due.size() == 0) begin
                $display("%0t: unexpected result %h/%b", $time, m_tdata, m_tuser);
                n_errors++;
            end else begin
                e = angles_due.pop_front();
                if (m_tuser) n_clamped++;
                if ($signed(m_tdata[15:0]) != e.roll) begin
                    $display("%0t: roll exp %0d got %0d", $time, e.roll,
                             $signed(m_tdata[15:0]));
                    n_errors++;
                end
                if ($signed(m_tdata[30:16]) != e.pitch) begin
                    $display("%0t: pitch exp %0d got %0d", $time, e.pitch,
                             $signed(m_tdata[30:16]));
                    n_errors++;
                end
                if ($signed(m_tdata[46:31]) != e.yaw) begin
                    $display("%0t: yaw exp %0d got %0d", $time, e.yaw,
                             $signed(m_tdata[46:31]));
                    n_errors++;
                end
                if (m_tuser !== e.clamped) begin
                    $display("%0t: clamp exp %b got %b", $time, e.clamped, m_tuser);
                    n_errors++;
                end
            end
        end
    end

    // sink backpressure: open stretches, short stalls, a few long ones
    initial begin
        int r, n;
        @(posedge aresetn);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(10, 60)) @(posedge aclk);
            end else begin
                idle_gap(n);
                m_tready <= (n == 0);
                repeat (n == 0 ? 1 : n) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("quaternion_to_euler_angles: mismatch");
            $finish;
        end
    end

    task automatic test_axes_and_zero();
        send_quat(16384, 0, 0, 0);
        send_quat(0, 0, 0, 0);
        send_quat(0, 16384, 0, 0);      // roll on negative real axis
        send_quat(0, 0, 0, 16384);      // yaw on negative real axis
        send_quat(-16384, 0, 0, 0);
        send_quat(11585, 11585, 0, 0);
        send_quat(11585, 0, 0, -11585);
        send_quat(8192, 8192, 8192, 8192);
    endtask

    task automatic test_pitch_saturation();
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(11586, 0, 11586, 0);
        send_quat(11584, 0, 11584, 0);
        send_quat(0, 11585, 0, -11585);
        send_quat(0, -11585, 0, -11585);
        send_quat(16384, 0, 16384, 0);
    endtask

    task automatic test_extreme_codes();
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(-32768, 32767, 0, 1);
        send_quat(16384, -16384, 16384, -16384);
        send_quat(-16384, 16384, -16384, 16384);
        send_quat(1, -1, 1, -1);
        send_quat(-1, 0, 0, 0);
    endtask

    task automatic test_random_orientations(int count);
        int r, k;
        logic signed [15:0] q [4];
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            for (k = 0; k < 4; k++) begin
                if (r < 70)
                    q[k] = 16'($signed($urandom_range(0, 32768)) - 16384);
                else if (r < 85)
                    q[k] = 16'($urandom);
                else
                    q[k] = 16'($signed($urandom_range(0, 64)) - 32);
            end
            if (r >= 85 && r < 95) begin
                // near the pitch singularity
                q[0] = 16'($signed($urandom_range(11570, 11600)));
                q[2] = ($urandom & 1) ? q[0] : -q[0];
            end
            send_quat(q[0], q[1], q[2], q[3]);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_axes_and_zero();
        test_pitch_saturation();
        test_extreme_codes();
        test_random_orientations(400);
        s_tvalid <= 1'b0;
        while (angles_due.size() != 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
        $display("covered %0d requests, %0d results, %0d with pitch saturated",
                 n_requests, n_results, n_clamped);
        if (n_errors == 0 && angles_due.size() == 0)
            $display("quaternion_to_euler_angles: match");
        else
            $display("quaternion_to_euler_angles: mismatch");
        $finish;
    end

endmodule
